>>> sv/gfdc_pkg.sv
// ----------------------------------------------------------------------------
// gfdc_pkg
// Shared types and constants of the gyro flywheel duty controller.
// ----------------------------------------------------------------------------
package gfdc_pkg;

   localparam int IndexWidth  = 8;
   localparam int SampleWidth = 16;
   localparam int StepWidth   = 7;
   localparam int GyroShift   = 8;

   localparam logic [StepWidth-1:0] COARSE_STEP_RESET = 7'd10;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_STOP   = 1'b1;

   typedef enum logic [1:0] {
      DRV_STOP    = 2'd0,
      DRV_FORWARD = 2'd1,
      DRV_REVERSE = 2'd2,
      DRV_BRAKE   = 2'd3
   } drive_type;

   // What one transaction asks of each motor.
   typedef enum logic [1:0] {
      OP_TRACK   = 2'd0,
      OP_BALANCE = 2'd1,
      OP_HALT    = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      drive_type             dir;
      logic [IndexWidth-1:0] mag;
   } probe_type;

   // Staged transaction from the input register.
   typedef struct packed {
      logic                   valid;
      logic                   command;
      logic [SampleWidth-1:0] sample;
   } stage_type;

endpackage

>>> sv/gyro_flywheel_duty_controller_unit.sv
// ----------------------------------------------------------------------------
// gyro_flywheel_duty_controller_unit
// Steers the duty index and drive direction of two flywheel motors from gyro
// z samples and stop events.
// ----------------------------------------------------------------------------
// Each transaction passes an input register and then the result register.
// The block takes one transaction per clock while the result is not stalled.
// The result register holds both motor states; a transaction moves into
// it only when the previous result has been taken, so a stalled result
// holds up at most one more waiting transaction before req_stall rises.
// Write csr_write_data only while idle.
module gyro_flywheel_duty_controller_unit import gfdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [StepWidth-1:0]   csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [SampleWidth-1:0] req_gyro_z_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [IndexWidth-1:0]  rsp_motor_a_index,
   output logic [IndexWidth-1:0]  rsp_motor_b_index,
   output logic [1:0]             rsp_motor_a_direction,
   output logic [1:0]             rsp_motor_b_direction
);

   logic [StepWidth-1:0]  coarse_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0] index_a_ff, index_a_in, index_b_ff, index_b_in;
   drive_type             drive_a_ff, drive_a_in, drive_b_ff, drive_b_in;
   stage_type             stage;
   probe_type             probe;
   logic                  advance;
   logic signed [IndexWidth-1:0] rate;

   assign advance = stage.valid && (!rsp_valid_ff || !rsp_stall);

   gfdc_input_stage u_input (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_gyro_z_sample (req_gyro_z_sample),
      .advance           (advance),
      .stage             (stage)
   );

   // Rate is the sample's high byte; zero and minus one count as balance.
   always_comb begin
      rate      = $signed(stage.sample[SampleWidth-1:GyroShift]);
      probe.dir = rate[IndexWidth-1] ? DRV_REVERSE : DRV_FORWARD;
      probe.mag = rate[IndexWidth-1] ? IndexWidth'(-rate) : IndexWidth'(rate);
      if (stage.command == CMD_STOP) begin
         probe.op = OP_HALT;
      end else if (rate == 8'sd0 || rate == -8'sd1) begin
         probe.op = OP_BALANCE;
      end else begin
         probe.op = OP_TRACK;
      end
   end

   gfdc_motor_step u_motor_a (
      .idx         (index_a_ff),
      .drv         (drive_a_ff),
      .probe       (probe),
      .coarse_step (coarse_ff),
      .idx_next    (index_a_in),
      .drv_next    (drive_a_in)
   );

   gfdc_motor_step u_motor_b (
      .idx         (index_b_ff),
      .drv         (drive_b_ff),
      .probe       (probe),
      .coarse_step (coarse_ff),
      .idx_next    (index_b_in),
      .drv_next    (drive_b_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_ff    <= COARSE_STEP_RESET;
         rsp_valid_ff <= 1'b0;
         index_a_ff   <= '0;
         index_b_ff   <= '0;
         drive_a_ff   <= DRV_STOP;
         drive_b_ff   <= DRV_STOP;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            coarse_ff <= csr_write_data;
         end
         if (advance) begin
            index_a_ff <= index_a_in;
            index_b_ff <= index_b_in;
            drive_a_ff <= drive_a_in;
            drive_b_ff <= drive_b_in;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_motor_a_index     = index_a_ff;
   assign rsp_motor_b_index     = index_b_ff;
   assign rsp_motor_a_direction = drive_a_ff;
   assign rsp_motor_b_direction = drive_b_ff;

endmodule

>>> sv/gfdc_input_stage.sv
// ----------------------------------------------------------------------------
// gfdc_input_stage
// Input register: holds one transaction until the step logic takes it.
// ----------------------------------------------------------------------------
module gfdc_input_stage import gfdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [SampleWidth-1:0] req_gyro_z_sample,
   input  logic                   advance,
   output stage_type              stage
);

   logic                   valid_ff, valid_in;
   logic                   command_ff;
   logic [SampleWidth-1:0] sample_ff;
   logic                   load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         command_ff <= req_command;
         sample_ff  <= req_gyro_z_sample;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.command = command_ff;
   assign stage.sample  = sample_ff;

endmodule

>>> sv/gfdc_motor_step.sv
// ----------------------------------------------------------------------------
// gfdc_motor_step
// Next index and drive of one motor for one transaction.
// ----------------------------------------------------------------------------
module gfdc_motor_step import gfdc_pkg::*; (
   input  logic [IndexWidth-1:0] idx,
   input  drive_type             drv,
   input  probe_type             probe,
   input  logic [StepWidth-1:0]  coarse_step,
   output logic [IndexWidth-1:0] idx_next,
   output drive_type             drv_next
);

   drive_type               against;
   logic signed [IndexWidth:0] gap;
   logic signed [IndexWidth:0] coarse_s;
   logic [IndexWidth-1:0]   coarse_w;
   logic [IndexWidth-1:0]   step;
   logic [IndexWidth-1:0]   slowed;

   always_comb begin
      against  = (probe.dir == DRV_FORWARD) ? DRV_REVERSE : DRV_FORWARD;
      coarse_w = IndexWidth'(coarse_step);
      coarse_s = $signed((IndexWidth+1)'(coarse_step));
      gap      = $signed({1'b0, probe.mag}) - $signed({1'b0, idx});
      step     = 8'd1;
      slowed   = idx;
      idx_next = idx;
      drv_next = drv;
      case (probe.op)
         OP_TRACK: begin
            if (drv == probe.dir) begin
               // Here the coarse step is chosen only when the gap to the magnitude is at least coarse_step.
               step = (gap >= coarse_s) ? coarse_w : 8'd1;
               if (probe.mag > idx) begin
                  idx_next = idx + step;
               end else if (probe.mag < idx) begin
                  idx_next = idx - step;
               end
            end else if (drv == against) begin
               step = (idx >= coarse_w) ? coarse_w : 8'd1;
               if (idx != '0) begin
                  slowed = idx - step;
               end
               idx_next = slowed;
               if (slowed == '0) begin
                  drv_next = DRV_BRAKE;
               end
            end else begin
               drv_next = probe.dir;
            end
         end
         OP_BALANCE: begin
            if (idx != '0) begin
               idx_next = idx - 8'd1;
            end
         end
         OP_HALT: begin
            drv_next = DRV_STOP;
         end
         default: begin
            idx_next = idx;
            drv_next = drv;
         end
      endcase
   end

endmodule
